/* hw/rtl/blr_pkg.sv */
`default_nettype none
package blr_pkg;

  localparam int COORD_W   = 16;
  localparam int PIX_X_W   = 10;
  localparam int PIX_Y_W   = 9;
  localparam int COLOR_W   = 4;
  localparam int SCREEN_W  = 640;
  localparam int SCREEN_H  = 480;
  localparam int CFG_IDX_W = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = CFG_IDX_W'(1);

  typedef struct packed {
    logic                       cmd;
    logic signed [COORD_W-1:0]  x_start;
    logic signed [COORD_W-1:0]  y_start;
    logic signed [COORD_W-1:0]  x_end;
    logic signed [COORD_W-1:0]  y_end;
    logic        [COLOR_W-1:0]  color;
  } blr_in_t;

  typedef struct packed {
    logic               pixel_valid;
    logic               visible;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
  } blr_out_t;

  // queued word: endpoints already shifted by the origin
  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COLOR_W-1:0] color;
  } blr_cmd_t;

  // queue status toward the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } blr_qstat_t;

endpackage
`default_nettype wire

/* hw/rtl/blr_front.sv */
`default_nettype none
module blr_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blr_pkg::COORD_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire blr_pkg::blr_in_t               in_data,
  input  wire blr_pkg::blr_qstat_t            qstat,
  output logic                                push,
  output blr_pkg::blr_cmd_t                   push_data
);
  import blr_pkg::*;

  logic [COORD_W-1:0] x_origin_r, x_origin_nxt;
  logic [COORD_W-1:0] y_origin_r, y_origin_nxt;

  always_comb begin
    x_origin_nxt = x_origin_r;
    y_origin_nxt = y_origin_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin_nxt = cfg_wdata;
        REG_Y_ORIGIN: y_origin_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
    end else begin
      x_origin_r <= x_origin_nxt;
      y_origin_r <= y_origin_nxt;
    end
  end

  assign in_ready = !qstat.full;
  assign push     = in_valid && !qstat.full;

  // shift endpoints by the origin, 16-bit wrap
  always_comb begin
    push_data.cmd   = in_data.cmd;
    push_data.xs    = $unsigned(in_data.x_start) + x_origin_r;
    push_data.ys    = $unsigned(in_data.y_start) + y_origin_r;
    push_data.xe    = $unsigned(in_data.x_end) + x_origin_r;
    push_data.ye    = $unsigned(in_data.y_end) + y_origin_r;
    push_data.color = in_data.color;
  end

endmodule
`default_nettype wire

/* hw/rtl/blr_queue.sv */
`default_nettype none
module blr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire blr_pkg::blr_cmd_t    push_data,
  input  wire logic                 pop,
  output blr_pkg::blr_qstat_t       qstat,
  output blr_pkg::blr_cmd_t         head
);
  import blr_pkg::*;

  blr_cmd_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == QCNT_W'($past(count_r) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

/* hw/rtl/blr_back.sv */
`default_nettype none
module blr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire blr_pkg::blr_qstat_t qstat,
  input  wire blr_pkg::blr_cmd_t   head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output blr_pkg::blr_out_t        out_data
);
  import blr_pkg::*;

  logic [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] delta_x_r, delta_x_nxt;
  logic [COORD_W-1:0] delta_y_r, delta_y_nxt;
  logic [COORD_W-1:0] error_acc_r, error_acc_nxt;
  logic [COORD_W-1:0] pixels_left_r, pixels_left_nxt;
  logic               x_neg_r, x_neg_nxt;
  logic               y_neg_r, y_neg_nxt;
  logic               x_major_r, x_major_nxt;
  logic [COLOR_W-1:0] line_color_r, line_color_nxt;
  logic               out_valid_r, out_valid_nxt;
  blr_out_t           out_r, out_nxt;

  logic               pop_start, pop_step;

  // line setup
  logic [COORD_W:0]   dx_s, dy_s;
  logic [COORD_W-1:0] dx_abs, dy_abs, setup_major;
  logic               setup_xmaj;

  // step datapath
  logic               line_live, vis;
  logic [COORD_W-1:0] x_stepped, y_stepped, maj_d, min_d, err_sum;
  logic               take_minor;

  assign pop       = !qstat.empty &&
                     (head.cmd == CMD_START || !out_valid_r || out_ready);
  assign pop_start = pop && head.cmd == CMD_START;
  assign pop_step  = pop && head.cmd == CMD_STEP;

  always_comb begin
    dx_s        = {head.xe[COORD_W-1], head.xe} - {head.xs[COORD_W-1], head.xs};
    dy_s        = {head.ye[COORD_W-1], head.ye} - {head.ys[COORD_W-1], head.ys};
    dx_abs      = dx_s[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dx_s) : dx_s[COORD_W-1:0];
    dy_abs      = dy_s[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dy_s) : dy_s[COORD_W-1:0];
    setup_xmaj  = dy_abs < dx_abs;
    setup_major = setup_xmaj ? dx_abs : dy_abs;
  end

  always_comb begin
    line_live  = pixels_left_r != '0;
    vis        = cur_x_r < COORD_W'(SCREEN_W) && cur_y_r < COORD_W'(SCREEN_H);
    x_stepped  = x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    y_stepped  = y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    maj_d      = x_major_r ? delta_x_r : delta_y_r;
    min_d      = x_major_r ? delta_y_r : delta_x_r;
    err_sum    = error_acc_r + min_d;
    take_minor = err_sum > maj_d;
  end

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    delta_x_nxt     = delta_x_r;
    delta_y_nxt     = delta_y_r;
    error_acc_nxt   = error_acc_r;
    pixels_left_nxt = pixels_left_r;
    x_neg_nxt       = x_neg_r;
    y_neg_nxt       = y_neg_r;
    x_major_nxt     = x_major_r;
    line_color_nxt  = line_color_r;
    if (pop_start) begin
      // a new line replaces any pending one
      cur_x_nxt       = head.xs;
      cur_y_nxt       = head.ys;
      delta_x_nxt     = dx_abs;
      delta_y_nxt     = dy_abs;
      x_neg_nxt       = dx_s[COORD_W] || dx_s == '0;
      y_neg_nxt       = dy_s[COORD_W] || dy_s == '0;
      x_major_nxt     = setup_xmaj;
      error_acc_nxt   = COORD_W'(((COORD_W+1)'(setup_major) + 1'b1) >> 1);
      pixels_left_nxt = setup_major;
      line_color_nxt  = head.color;
    end else if (pop_step && line_live) begin
      error_acc_nxt   = take_minor ? err_sum - maj_d : err_sum;
      cur_x_nxt       = (x_major_r || take_minor) ? x_stepped : cur_x_r;
      cur_y_nxt       = (!x_major_r || take_minor) ? y_stepped : cur_y_r;
      pixels_left_nxt = pixels_left_r - 1'b1;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (pop_step) begin
      out_nxt = '0;
      if (line_live) begin
        out_nxt.pixel_valid = 1'b1;
        out_nxt.visible     = vis;
        out_nxt.pixel_x     = vis ? cur_x_r[PIX_X_W-1:0] : '0;
        out_nxt.pixel_y     = vis ? cur_y_r[PIX_Y_W-1:0] : '0;
        out_nxt.pixel_color = line_color_r;
        out_nxt.last        = pixels_left_r == COORD_W'(1);
      end
    end
    priority if (pop_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    delta_x_r    <= delta_x_nxt;
    delta_y_r    <= delta_y_nxt;
    error_acc_r  <= error_acc_nxt;
    x_neg_r      <= x_neg_nxt;
    y_neg_r      <= y_neg_nxt;
    x_major_r    <= x_major_nxt;
    line_color_r <= line_color_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_step && pixels_left_r == COORD_W'(1)) |=> pixels_left_r == '0)
    else $error("line still pending after its last pixel");
  a_visible_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.visible) |->
      (out_r.pixel_x < PIX_X_W'(SCREEN_W) && out_r.pixel_y < PIX_Y_W'(SCREEN_H)))
    else $error("visible pixel off screen");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.pixel_valid) |-> out_r == '0)
    else $error("empty step result carries data");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop_step)
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

/* hw/rtl/bresenham_line_rasterizer.sv */
// An accepted step word passes through the queue into the out_data register, unless
// a held result blocks the back end. Throughput: one word per cycle while the queue is
// not full; the two-entry queue decouples input from output, and the back end advances
// one pixel per cycle with an add, a compare and a subtract while no held result blocks
// it. A start word produces no result.
// Reset (synchronous, rst_n low) clears both origins, the queue, out_valid, and any line.
`default_nettype none
module bresenham_line_rasterizer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blr_pkg::COORD_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire blr_pkg::blr_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output blr_pkg::blr_out_t                   out_data
);
  import blr_pkg::*;

  blr_qstat_t qstat;
  blr_cmd_t   push_data, head;
  logic       push, pop;

  blr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  blr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .qstat     (qstat),
    .head      (head)
  );

  blr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* dv/blr_checker.sv */
module blr_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blr_pkg::COORD_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire blr_pkg::blr_in_t               in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire blr_pkg::blr_out_t              out_data,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  pixels_seen,
  output int                                  visible_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  logic [COORD_W-1:0] org_x, org_y;
  logic [COORD_W-1:0] pos_x, pos_y, run_dx, run_dy, err_term, steps_left;
  logic               x_neg, y_neg, walk_x;
  logic [COLOR_W-1:0] ink;

  blr_out_t pixel_q[$];
  int       bad_cnt, pix_cnt, vis_cnt;

  // Advance the line walker by one accepted word; step words queue one expected output word.
  task automatic trace_word(input blr_in_t w);
    logic [COORD_W-1:0] xs, ys, xe, ye, major, xstep, ystep;
    int                 dx, dy;
    logic               vis;
    blr_out_t           px;
    if (w.cmd == CMD_START) begin
      xs = w.x_start + org_x;
      ys = w.y_start + org_y;
      xe = w.x_end + org_x;
      ye = w.y_end + org_y;
      dx = int'($signed(xe)) - int'($signed(xs));
      dy = int'($signed(ye)) - int'($signed(ys));
      pos_x  = xs;
      pos_y  = ys;
      x_neg  = !(dx > 0);
      y_neg  = !(dy > 0);
      run_dx = COORD_W'((dx < 0) ? -dx : dx);
      run_dy = COORD_W'((dy < 0) ? -dy : dy);
      walk_x = run_dy < run_dx;
      major  = walk_x ? run_dx : run_dy;
      err_term   = COORD_W'(({1'b0, major} + 17'd1) >> 1);
      steps_left = major;
      ink        = w.color;
    end else if (steps_left == '0) begin
      pixel_q.push_back('0);
    end else begin
      vis = (pos_x < SCREEN_W) && (pos_y < SCREEN_H);
      px.pixel_valid = 1'b1;
      px.visible     = vis;
      px.pixel_x     = vis ? pos_x[PIX_X_W-1:0] : '0;
      px.pixel_y     = vis ? pos_y[PIX_Y_W-1:0] : '0;
      px.pixel_color = ink;
      px.last        = (steps_left == 16'd1);
      pixel_q.push_back(px);
      xstep = x_neg ? 16'hFFFF : 16'h0001;
      ystep = y_neg ? 16'hFFFF : 16'h0001;
      if (walk_x) begin
        pos_x    = pos_x + xstep;
        err_term = err_term + run_dy;
        if (err_term > run_dx) begin
          err_term = err_term - run_dx;
          pos_y    = pos_y + ystep;
        end
      end else begin
        pos_y    = pos_y + ystep;
        err_term = err_term + run_dx;
        if (err_term > run_dy) begin
          err_term = err_term - run_dy;
          pos_x    = pos_x + xstep;
        end
      end
      steps_left = steps_left - 16'd1;
    end
  endtask

  task automatic check_pixel(input blr_out_t got);
    blr_out_t want;
    if (pixel_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("%0t: pixel word with nothing expected: %s",
                 $realtime,
                 $sformatf("valid=%0d vis=%0d x=%0d y=%0d c=%0d last=%0d",
                           got.pixel_valid, got.visible, got.pixel_x, got.pixel_y,
                           got.pixel_color, got.last));
      return;
    end
    want = pixel_q.pop_front();
    pix_cnt++;
    if (want.visible) vis_cnt++;
    if (got.pixel_valid !== want.pixel_valid || got.visible !== want.visible ||
        got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
        got.pixel_color !== want.pixel_color || got.last !== want.last) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("%0t: pixel mismatch: expected %s, got %s",
                 $realtime,
                 $sformatf("valid=%0d vis=%0d x=%0d y=%0d c=%0d last=%0d",
                           want.pixel_valid, want.visible, want.pixel_x, want.pixel_y,
                           want.pixel_color, want.last),
                 $sformatf("valid=%0d vis=%0d x=%0d y=%0d c=%0d last=%0d",
                           got.pixel_valid, got.visible, got.pixel_x, got.pixel_y,
                           got.pixel_color, got.last));
    end
  endtask

  initial begin
    bad_cnt = 0;
    pix_cnt = 0;
    vis_cnt = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      org_x      = '0;
      org_y      = '0;
      pos_x      = '0;
      pos_y      = '0;
      run_dx     = '0;
      run_dy     = '0;
      err_term   = '0;
      steps_left = '0;
      x_neg      = 1'b0;
      y_neg      = 1'b0;
      walk_x     = 1'b0;
      ink        = '0;
      pixel_q.delete();
    end else begin
      // pop before push: a word accepted at this edge cannot leave at this edge
      if (out_valid && out_ready) check_pixel(out_data);
      if (in_valid && in_ready) trace_word(in_data);
      if (cfg_we) begin
        if (cfg_index == REG_X_ORIGIN) org_x = cfg_wdata;
        else if (cfg_index == REG_Y_ORIGIN) org_y = cfg_wdata;
      end
    end
    pending      <= pixel_q.size();
    mismatches   <= bad_cnt;
    pixels_seen  <= pix_cnt;
    visible_seen <= vis_cnt;
  end

endmodule

/* dv/tb_bresenham_line_rasterizer.sv */
module tb_bresenham_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_ORIGIN;
  logic [COORD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  blr_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  blr_out_t             out_data;

  int mismatches, pending, pixels_seen, visible_seen;
  int sent = 0;
  int org_x = 0;
  int org_y = 0;
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;

  bresenham_line_rasterizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  blr_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .pixels_seen  (pixels_seen),
    .visible_seen (visible_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall before each word, none while quiet_out is set.
  initial begin
    int gap;
    forever begin
      gap = quiet_out ? 0 : $urandom_range(7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic blr_in_t mk_start(int xs, int ys, int xe, int ye, int c);
    blr_in_t w;
    w.cmd     = CMD_START;
    w.x_start = 16'(xs);
    w.y_start = 16'(ys);
    w.x_end   = 16'(xe);
    w.y_end   = 16'(ye);
    w.color   = 4'(c);
    return w;
  endfunction

  // Step words carry random junk in the unused fields.
  function automatic blr_in_t mk_step();
    blr_in_t w;
    w = blr_in_t'({$urandom, $urandom, $urandom});
    w.cmd = CMD_STEP;
    return w;
  endfunction

  task automatic send_word(input blr_in_t w);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_word(mk_step());
  endtask

  // Hold off until every pixel is out, then let a trailing start word retire.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_origin(input int xo, input int yo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_X_ORIGIN;
    cfg_wdata <= 16'(xo);
    @(posedge clk);
    cfg_index <= REG_Y_ORIGIN;
    cfg_wdata <= 16'(yo);
    @(posedge clk);
    cfg_we <= 1'b0;
    org_x = xo;
    org_y = yo;
  endtask

  // Line given in screen space; endpoints are sent relative to the origin.
  task automatic screen_line(input int span);
    int sx, sy, dx, dy, major, steps, cut;
    sx = int'($urandom_range(659)) - 10;
    sy = int'($urandom_range(499)) - 10;
    dx = int'($urandom_range(2 * span)) - span;
    dy = int'($urandom_range(2 * span)) - span;
    major = (dx < 0 ? -dx : dx);
    if ((dy < 0 ? -dy : dy) > major) major = (dy < 0 ? -dy : dy);
    cut = $urandom_range(9);
    if (cut == 0) steps = $urandom_range(major);
    else steps = major + (cut == 1);
    send_word(mk_start(sx - org_x, sy - org_y, sx + dx - org_x, sy + dy - org_y,
                       $urandom_range(15)));
    send_steps(steps);
  endtask

  task automatic random_phase(input int words);
    int stop, r, v;
    stop = sent + words;
    while (sent < stop) begin
      quiet_in  = ($urandom_range(4) == 0);
      quiet_out = ($urandom_range(4) == 0);
      r = $urandom_range(99);
      if (r < 70) begin
        screen_line(12);
      end else if (r < 73) begin
        screen_line(300);
      end else if (r < 85) begin
        // full-range endpoints: walk a few pixels, usually replaced later
        send_word(mk_start($urandom, $urandom, $urandom, $urandom, $urandom));
        send_steps($urandom_range(4));
      end else if (r < 93) begin
        v = $urandom;
        send_word(mk_start(v, v >> 16, v, v >> 16, $urandom));
        send_steps($urandom_range(2));
      end else begin
        send_steps($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle step, shallow, degenerate, steep backward, screen corner, extremes
    send_steps(1);
    send_word(mk_start(0, 0, 5, 2, 15));
    send_steps(6);
    send_word(mk_start(10, 10, 10, 10, 3));
    send_steps(1);
    send_word(mk_start(3, 4, 1, 0, 0));
    send_steps(4);
    send_word(mk_start(638, 478, 642, 482, 9));
    send_steps(4);
    send_word(mk_start(-32768, -32768, 32767, 32767, 10));
    send_steps(2);
    send_word(mk_start(32767, 32767, -32768, -32768, 5));
    send_steps(1);
    drain();

    for (i = 0; i < 5; i++) begin
      case (i)
        0: set_origin(32767, -32768);
        1: set_origin(-32768, 32767);
        2: set_origin(0, 0);
        default: set_origin(int'($urandom_range(65535)) - 32768,
                            int'($urandom_range(65535)) - 32768);
      endcase
      random_phase(175);
      drain();
    end

    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    drain();
    $display("Covered %0d input words over 6 origin settings;", sent);
    $display("%0d pixel words checked, %0d visible.", pixels_seen, visible_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/blr_pkg.sv
hw/rtl/blr_front.sv
hw/rtl/blr_queue.sv
hw/rtl/blr_back.sv
hw/rtl/bresenham_line_rasterizer.sv
dv/blr_checker.sv
dv/tb_bresenham_line_rasterizer.sv
